/* hw/rtl/smudge_paint_alpha_blend_unit_defines.svh */
// Assertion macros shared by the smudge paint blend checker.
// No dependencies; included by files that assert.
`ifndef SMUDGE_PAINT_ALPHA_BLEND_UNIT_DEFINES_SVH
`define SMUDGE_PAINT_ALPHA_BLEND_UNIT_DEFINES_SVH

// same-cycle implication, reset masked
`define SPB_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, reset masked
`define SPB_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/spb_pkg.sv */
// Types and constants for the smudge paint alpha blend unit.
// No dependencies.
package spb_pkg;

    localparam int PIXEL_W  = 64;
    localparam int WEIGHT_W = 17;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 64;
    localparam int WEIGHT_SHIFT = 16;
    localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = 17'd65536;

    localparam logic [CFG_IDX_W-1:0] REG_SMUDGE_RATE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PAINT_FLOW  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KEEP_ALPHA  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PURE_SMUDGE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_USE_BRUSH   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_BRUSH_COLOR = 3'd5;

    typedef struct packed {
        logic [PIXEL_W-1:0] accum_pixel;
        logic [PIXEL_W-1:0] canvas_pixel;
        logic [PIXEL_W-1:0] paint_pixel;
        logic               last_in;
    } px_in_t;

    typedef struct packed {
        logic [PIXEL_W-1:0] accum_out;
        logic [PIXEL_W-1:0] paint_out;
        logic               last_out;
    } px_out_t;

endpackage

/* hw/rtl/spb_blend.sv */
// One alpha-weighted RGBA blend, pipelined: weights, products, sum, one quotient
// bit per stage, output. Depends on spb_pkg.
module spb_blend #(
    parameter int CHANNEL_BITS = 16,
    parameter int SIDE_W = 65
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         en,
    input  logic                         in_vld,
    input  logic [spb_pkg::PIXEL_W-1:0]  p1,
    input  logic [spb_pkg::WEIGHT_W-1:0] w1,
    input  logic [spb_pkg::PIXEL_W-1:0]  p2,
    input  logic [spb_pkg::WEIGHT_W-1:0] w2,
    input  logic                         keep_alpha,
    input  logic [SIDE_W-1:0]            side_in,
    output logic                         out_vld,
    output logic [spb_pkg::PIXEL_W-1:0]  out_px,
    output logic [SIDE_W-1:0]            side_out
);
    import spb_pkg::*;

    localparam int CB = CHANNEL_BITS;
    localparam int SW = WEIGHT_SHIFT + CB;
    localparam int NW = SW + CB;
    localparam int ND = CB;

    // stage 1: alpha weights
    logic [WEIGHT_W+CB-1:0] wa1_full;
    logic [WEIGHT_W+CB-1:0] wa2_full;
    logic              s1_vld_reg;
    logic [SW-1:0]     s1_wa1_reg;
    logic [SW-1:0]     s1_wa2_reg;
    logic [CB-1:0]     s1_c1_reg [3];
    logic [CB-1:0]     s1_c2_reg [3];
    logic [CB-1:0]     s1_a2_reg;
    logic [SIDE_W-1:0] s1_side_reg;

    // stage 2: colour products
    logic              s2_vld_reg;
    logic [SW-1:0]     s2_sum_reg;
    logic [NW-1:0]     s2_pa_reg [3];
    logic [NW-1:0]     s2_pb_reg [3];
    logic [CB-1:0]     s2_a2_reg;
    logic [SIDE_W-1:0] s2_side_reg;

    // divider stages, index 0 holds the numerator
    logic              d_vld_reg  [ND+1];
    logic [NW-1:0]     d_rem_reg  [ND+1][3];
    logic [CB-1:0]     d_q_reg    [ND+1][3];
    logic [SW-1:0]     d_sum_reg  [ND+1];
    logic [CB-1:0]     d_a2_reg   [ND+1];
    logic [SIDE_W-1:0] d_side_reg [ND+1];

    logic              o_vld_reg;
    logic [PIXEL_W-1:0] o_px_reg;
    logic [PIXEL_W-1:0] o_px_next;
    logic [SIDE_W-1:0] o_side_reg;
    logic [CB-1:0]     alpha;

    assign wa1_full = w1 * p1[3*CB +: CB];
    assign wa2_full = w2 * p2[3*CB +: CB];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
            d_vld_reg[0] <= 1'b0;
            o_vld_reg  <= 1'b0;
        end
        else if (en)
        begin
            s1_vld_reg <= in_vld;
            s2_vld_reg <= s1_vld_reg;
            d_vld_reg[0] <= s2_vld_reg;
            o_vld_reg  <= d_vld_reg[ND];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_wa1_reg  <= wa1_full[SW-1:0];
            s1_wa2_reg  <= wa2_full[SW-1:0];
            s1_a2_reg   <= p2[3*CB +: CB];
            s1_side_reg <= side_in;
            for (int k = 0; k < 3; k++)
            begin
                s1_c1_reg[k] <= p1[k*CB +: CB];
                s1_c2_reg[k] <= p2[k*CB +: CB];
            end

            s2_sum_reg  <= s1_wa1_reg + s1_wa2_reg;
            s2_a2_reg   <= s1_a2_reg;
            s2_side_reg <= s1_side_reg;
            for (int k = 0; k < 3; k++)
            begin
                s2_pa_reg[k] <= s1_c1_reg[k] * s1_wa1_reg;
                s2_pb_reg[k] <= s1_c2_reg[k] * s1_wa2_reg;
            end

            d_sum_reg[0]  <= s2_sum_reg;
            d_a2_reg[0]   <= s2_a2_reg;
            d_side_reg[0] <= s2_side_reg;
            for (int k = 0; k < 3; k++)
            begin
                d_rem_reg[0][k] <= s2_pa_reg[k] + s2_pb_reg[k];
                d_q_reg[0][k]   <= '0;
            end

            o_px_reg   <= o_px_next;
            o_side_reg <= d_side_reg[ND];
        end
    end

    for (genvar j = 0; j < ND; j++)
    begin : g_div
        localparam int BIT = ND - 1 - j;
        logic [NW-1:0] dvs;
        logic [NW-1:0] rem_next [3];
        logic [CB-1:0] q_next [3];

        assign dvs = {{CB{1'b0}}, d_sum_reg[j]} << BIT;

        always_comb
        begin
            for (int k = 0; k < 3; k++)
            begin
                if (d_rem_reg[j][k] >= dvs)
                begin
                    rem_next[k] = d_rem_reg[j][k] - dvs;
                    q_next[k]   = d_q_reg[j][k] | (CB'(1) << BIT);
                end
                else
                begin
                    rem_next[k] = d_rem_reg[j][k];
                    q_next[k]   = d_q_reg[j][k];
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                d_vld_reg[j+1] <= 1'b0;
            end
            else if (en)
            begin
                d_vld_reg[j+1] <= d_vld_reg[j];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                d_sum_reg[j+1]  <= d_sum_reg[j];
                d_a2_reg[j+1]   <= d_a2_reg[j];
                d_side_reg[j+1] <= d_side_reg[j];
                for (int k = 0; k < 3; k++)
                begin
                    d_rem_reg[j+1][k] <= rem_next[k];
                    d_q_reg[j+1][k]   <= q_next[k];
                end
            end
        end
    end

    always_comb
    begin
        alpha = d_sum_reg[ND][SW-1:WEIGHT_SHIFT];
        if (keep_alpha && (alpha < d_a2_reg[ND]))
        begin
            alpha = d_a2_reg[ND];
        end
        o_px_next = '0;
        if (d_sum_reg[ND] != '0)
        begin
            for (int k = 0; k < 3; k++)
            begin
                o_px_next[k*CB +: CB] = d_q_reg[ND][k];
            end
            o_px_next[3*CB +: CB] = alpha;
        end
    end

    assign out_vld  = o_vld_reg;
    assign out_px   = o_px_reg;
    assign side_out = o_side_reg;

endmodule

/* hw/rtl/smudge_paint_alpha_blend_unit.sv */
// Input accept to output valid runs through u_accum and then u_paint, each fully registered.
// Throughput: one item per cycle unless stalled; one quotient bit per divider stage.
// A stalled output freezes the whole pipeline; no item is dropped or repeated.
// Reset (async, active low) clears valid bits and loads configuration defaults.
// Depends on spb_pkg and spb_blend.
module smudge_paint_alpha_blend_unit #(
    parameter int CHANNEL_BITS = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_wr_en,
    input  logic [spb_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [spb_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  spb_pkg::px_in_t                in_data,
    output logic                           out_valid,
    input  logic                           out_ready,
    output spb_pkg::px_out_t               out_data
);
    import spb_pkg::*;

    localparam int SIDE_W = PIXEL_W + 1;

    logic [WEIGHT_W-1:0] smudge_rate_reg;
    logic [WEIGHT_W-1:0] paint_flow_reg;
    logic                keep_alpha_reg;
    logic                pure_smudge_reg;
    logic                use_brush_reg;
    logic [PIXEL_W-1:0]  brush_color_reg;

    logic [WEIGHT_W-1:0] rate;
    logic [WEIGHT_W-1:0] flow;
    logic                en;

    logic                b1_vld;
    logic [PIXEL_W-1:0]  b1_px;
    logic [SIDE_W-1:0]   b1_side;
    logic [PIXEL_W-1:0]  src_px;
    logic                b2_vld;
    logic [PIXEL_W-1:0]  b2_px;
    logic [SIDE_W-1:0]   b2_side;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            smudge_rate_reg <= 17'd32768;
            paint_flow_reg  <= 17'd32768;
            keep_alpha_reg  <= 1'b0;
            pure_smudge_reg <= 1'b0;
            use_brush_reg   <= 1'b1;
            brush_color_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_SMUDGE_RATE: smudge_rate_reg <= cfg_data[WEIGHT_W-1:0];
                REG_PAINT_FLOW:  paint_flow_reg  <= cfg_data[WEIGHT_W-1:0];
                REG_KEEP_ALPHA:  keep_alpha_reg  <= cfg_data[0];
                REG_PURE_SMUDGE: pure_smudge_reg <= cfg_data[0];
                REG_USE_BRUSH:   use_brush_reg   <= cfg_data[0];
                REG_BRUSH_COLOR: brush_color_reg <= cfg_data[PIXEL_W-1:0];
                default: ;
            endcase
        end
    end

    assign rate = (smudge_rate_reg > WEIGHT_ONE) ? WEIGHT_ONE : smudge_rate_reg;
    assign flow = (paint_flow_reg > WEIGHT_ONE) ? WEIGHT_ONE : paint_flow_reg;

    assign en       = !b2_vld || out_ready;
    assign in_ready = en;

    spb_blend #(
        .CHANNEL_BITS(CHANNEL_BITS),
        .SIDE_W(SIDE_W)
    ) u_accum (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .in_vld     (in_valid),
        .p1         (in_data.accum_pixel),
        .w1         (rate),
        .p2         (in_data.canvas_pixel),
        .w2         (WEIGHT_ONE - rate),
        .keep_alpha (keep_alpha_reg),
        .side_in    ({in_data.last_in, in_data.paint_pixel}),
        .out_vld    (b1_vld),
        .out_px     (b1_px),
        .side_out   (b1_side)
    );

    assign src_px = use_brush_reg ? brush_color_reg : b1_side[PIXEL_W-1:0];

    spb_blend #(
        .CHANNEL_BITS(CHANNEL_BITS),
        .SIDE_W(SIDE_W)
    ) u_paint (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .in_vld     (b1_vld),
        .p1         (src_px),
        .w1         (flow),
        .p2         (b1_px),
        .w2         (WEIGHT_ONE - flow),
        .keep_alpha (keep_alpha_reg),
        .side_in    ({b1_side[PIXEL_W], b1_px}),
        .out_vld    (b2_vld),
        .out_px     (b2_px),
        .side_out   (b2_side)
    );

    assign out_valid          = b2_vld;
    assign out_data.accum_out = b2_side[PIXEL_W-1:0];
    assign out_data.paint_out = pure_smudge_reg ? b2_side[PIXEL_W-1:0] : b2_px;
    assign out_data.last_out  = b2_side[PIXEL_W];

endmodule

/* hw/rtl/spb_checker.sv */
// Port-level checks for the smudge paint alpha blend unit, bound to the top level.
// Depends on spb_pkg and smudge_paint_alpha_blend_unit_defines.svh.
`include "smudge_paint_alpha_blend_unit_defines.svh"

module spb_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           in_ready,
    input logic                           out_valid,
    input logic                           out_ready,
    input spb_pkg::px_out_t               out_data
);
    import spb_pkg::*;

    `SPB_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "output item dropped")
    `SPB_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(out_data), "stalled item changed")
    `SPB_ASSERT_NOW(a_stall_blocks, out_valid && !out_ready, !in_ready, "input taken while stalled")
    `SPB_ASSERT_NOW(a_empty_ready, !out_valid, in_ready, "input refused with empty output")

endmodule

bind smudge_paint_alpha_blend_unit spb_checker u_spb_checker (.*);

/* tb/tb.sv */
// Testbench for smudge_paint_alpha_blend_unit: random and directed pixels, with a
// scoreboard class that predicts the two chained alpha blends and checks each result.
// Depends on spb_pkg and the unit's RTL.
`timescale 1ns / 1ps

class blend_scoreboard;
    logic [16:0] rate_q = 17'd32768;
    logic [16:0] flow_q = 17'd32768;
    bit keep_q = 0;
    bit pure_q = 0;
    bit brush_sel_q = 1;
    logic [63:0] brush_q = '0;
    spb_pkg::px_out_t pending_px[$];
    int errors = 0;

    function void write_reg(logic [2:0] idx, logic [63:0] val);
        case (idx)
            spb_pkg::REG_SMUDGE_RATE: rate_q = val[16:0];
            spb_pkg::REG_PAINT_FLOW:  flow_q = val[16:0];
            spb_pkg::REG_KEEP_ALPHA:  keep_q = val[0];
            spb_pkg::REG_PURE_SMUDGE: pure_q = val[0];
            spb_pkg::REG_USE_BRUSH:   brush_sel_q = val[0];
            spb_pkg::REG_BRUSH_COLOR: brush_q = val;
            default: ;
        endcase
    endfunction

    function logic [63:0] mix(logic [63:0] p1, logic [16:0] w1, logic [63:0] p2,
                              logic [16:0] w2);
        logic [63:0] wa1, wa2, total, num, res, alpha;
        wa1 = 64'(w1) * 64'(p1[63:48]);
        wa2 = 64'(w2) * 64'(p2[63:48]);
        total = wa1 + wa2;
        res = '0;
        if (total == 64'd0)
            return '0;
        for (int k = 0; k < 3; k++)
        begin
            num = 64'(p1[16*k +: 16]) * wa1 + 64'(p2[16*k +: 16]) * wa2;
            res[16*k +: 16] = 16'(num / total);
        end
        alpha = total >> 16;
        if (keep_q && alpha < 64'(p2[63:48]))
            alpha = 64'(p2[63:48]);
        res[63:48] = alpha[15:0];
        return res;
    endfunction

    function void note_input(spb_pkg::px_in_t px);
        logic [16:0] r, f;
        spb_pkg::px_out_t o;
        r = (rate_q > 17'd65536) ? 17'd65536 : rate_q;
        f = (flow_q > 17'd65536) ? 17'd65536 : flow_q;
        o.accum_out = mix(px.accum_pixel, r, px.canvas_pixel, 17'd65536 - r);
        if (pure_q)
            o.paint_out = o.accum_out;
        else
            o.paint_out = mix(brush_sel_q ? brush_q : px.paint_pixel, f,
                              o.accum_out, 17'd65536 - f);
        o.last_out = px.last_in;
        pending_px.push_back(o);
    endfunction

    task report(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch %s: got %h want %h", what, got, want);
        errors++;
    endtask

    task check_result(spb_pkg::px_out_t got);
        spb_pkg::px_out_t want;
        if (pending_px.size() == 0)
        begin
            report("unexpected item", 64'(got.accum_out), 64'd0);
            return;
        end
        want = pending_px.pop_front();
        if (got.accum_out !== want.accum_out) report("accum_out", got.accum_out, want.accum_out);
        if (got.paint_out !== want.paint_out) report("paint_out", got.paint_out, want.paint_out);
        if (got.last_out !== want.last_out) report("last_out", 64'(got.last_out), 64'(want.last_out));
    endtask
endclass

module tb;
    import spb_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 3'd7;

    logic clk = 0;
    logic rst_n = 0;
    logic cfg_wr_en = 0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic in_valid = 0;
    logic in_ready;
    px_in_t in_data = '0;
    logic out_valid;
    logic out_ready = 0;
    px_out_t out_data;

    blend_scoreboard sb = new();
    bit idle_on = 1;
    int cycles = 0;
    int pixels_sent = 0;
    int pixels_seen = 0;

    always #1 clk = ~clk;

    smudge_paint_alpha_blend_unit dut (.*);

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > 400000)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("tb failed");
            $finish;
        end
        if (rst_n && in_valid && in_ready) sb.note_input(in_data);
        if (rst_n && out_valid && out_ready)
        begin
            sb.check_result(out_data);
            pixels_seen++;
        end
    end

    // receiver stalls in bursts
    initial
    begin
        int n;
        forever
        begin
            @(negedge clk);
            if (idle_on && $urandom_range(0, 5) == 0)
            begin
                out_ready <= 1'b0;
                n = $urandom_range(1, 12);
                repeat (n) @(negedge clk);
            end
            out_ready <= 1'b1;
        end
    end

    task automatic write_reg(logic [2:0] idx, logic [63:0] val);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        sb.write_reg(idx, val);
        @(negedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    // valid stays high between items except in random idle gaps; drain() drops it
    task automatic send_pixel(px_in_t px);
        int n;
        if (idle_on && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            n = $urandom_range(1, 12);
            repeat (n) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data <= px;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        pixels_sent++;
        @(negedge clk);
    endtask

    function automatic logic [15:0] rand_chan();
        case ($urandom_range(0, 3))
            0: return 16'h0;
            1: return 16'hFFFF;
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    function automatic logic [63:0] rand_px();
        return {rand_chan(), rand_chan(), rand_chan(), rand_chan()};
    endfunction

    function automatic logic [16:0] rand_weight();
        case ($urandom_range(0, 4))
            0: return 17'd0;
            1: return 17'd65536;
            2: return 17'h1FFFF;
            default: return 17'($urandom_range(0, 131071));
        endcase
    endfunction

    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending_px.size() != 0) @(posedge clk);
        repeat (50) @(posedge clk);
    endtask

    task automatic send_random(int count);
        px_in_t px;
        for (int i = 0; i < count; i++)
        begin
            px.accum_pixel = rand_px();
            px.canvas_pixel = rand_px();
            px.paint_pixel = rand_px();
            px.last_in = 1'($urandom_range(0, 1));
            send_pixel(px);
        end
    endtask

    initial
    begin
        px_in_t px;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1;

        // directed: extremes, zero alpha, tiny alpha, each mode
        px = '{64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1};
        send_pixel(px);
        px = '{64'h0, 64'h0, 64'h0, 1'b0};
        send_pixel(px);
        px = '{64'h0001_1234_5678_9ABC, 64'h0000_FFFF_0000_FFFF, 64'h0001_0001_0001_0001, 1'b1};
        send_pixel(px);
        px = '{64'h0000_FFFF_FFFF_FFFF, 64'h8000_0001_0002_0003, 64'hFFFF_0000_0000_0000, 1'b0};
        send_pixel(px);
        drain();
        write_reg(REG_KEEP_ALPHA, 64'd1);
        write_reg(REG_BRUSH_COLOR, 64'h8000_FFFF_0000_1234);
        write_reg(REG_SMUDGE_RATE, 64'h1FFFF);
        write_reg(REG_PAINT_FLOW, 64'd0);
        write_reg(REG_UNMAPPED, 64'hFFFF);
        send_random(8);
        drain();
        write_reg(REG_PURE_SMUDGE, 64'd1);
        write_reg(REG_SMUDGE_RATE, 64'd0);
        send_random(6);
        drain();
        write_reg(REG_PURE_SMUDGE, 64'd0);
        write_reg(REG_USE_BRUSH, 64'd0);
        write_reg(REG_PAINT_FLOW, 64'd65536);
        send_random(6);
        drain();

        for (int phase = 0; phase < 8; phase++)
        begin
            write_reg(REG_SMUDGE_RATE, 64'(rand_weight()));
            write_reg(REG_PAINT_FLOW, 64'(rand_weight()));
            write_reg(REG_KEEP_ALPHA, 64'($urandom_range(0, 1)));
            write_reg(REG_PURE_SMUDGE, 64'($urandom_range(0, 3) == 0));
            write_reg(REG_USE_BRUSH, 64'($urandom_range(0, 1)));
            write_reg(REG_BRUSH_COLOR, rand_px());
            if (phase == 7) idle_on = 0;
            send_random(100);
            drain();
        end

        $display("sent %0d pixels, checked %0d results", pixels_sent, pixels_seen);
        $display("covered reset defaults, three directed setups and eight random setups");
        if (sb.errors == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end
endmodule
